// File: rtl/lrs_pkg.sv
// Types, codes and helper functions for the line rasterizer stepper.
// Depends on nothing; used by rtl/line_rasterizer_step.sv.
`timescale 1ns / 1ps

package lrs_pkg;

    localparam int COORD_BITS = 12;
    // The decision term spans -2*|major| .. 2*|major| and needs a sign bit.
    localparam int ERR_BITS = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    typedef enum logic
    {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } action_t;

    // Octants counted counterclockwise from the positive x axis.
    typedef enum logic [2:0]
    {
        OCT_0 = 3'd0,
        OCT_1 = 3'd1,
        OCT_2 = 3'd2,
        OCT_3 = 3'd3,
        OCT_4 = 3'd4,
        OCT_5 = 3'd5,
        OCT_6 = 3'd6,
        OCT_7 = 3'd7
    } octant_t;

    typedef struct packed
    {
        action_t action;
        coord_t  start_x;
        coord_t  start_y;
        coord_t  end_x;
        coord_t  end_y;
    } req_t;

    typedef struct packed
    {
        coord_t  point_x;
        coord_t  point_y;
        logic    on_line;
        octant_t octant;
    } res_t;

    function automatic logic major_is_x(octant_t oct);
        return oct inside {OCT_0, OCT_3, OCT_4, OCT_7};
    endfunction

    function automatic logic x_forward(octant_t oct);
        return oct inside {OCT_0, OCT_1, OCT_6, OCT_7};
    endfunction

    function automatic logic y_forward(octant_t oct);
        return oct inside {OCT_0, OCT_1, OCT_2, OCT_3};
    endfunction

    function automatic coord_t move1(coord_t v, logic fwd);
        return fwd ? (v + coord_t'(1)) : (v - coord_t'(1));
    endfunction

endpackage

// File: rtl/line_rasterizer_step.sv
// Line rasterizer stepper top level: request channel, line state and result register.
// Depends on rtl/lrs_pkg.sv.
`timescale 1ns / 1ps

// Bresenham line stepper for all eight octants. A load request latches start and end
// points and returns the start point; each step request advances one pixel along the
// major axis and returns the new point with on_line set until the end point has been
// passed, after which the position holds and on_line reads 0. The block accepts one
// request per clock while no result waits or the waiting one is taken, and returns
// its result in the cycle after acceptance; each step needs the update of the decision
// term (an add, a conditional subtract and a sign test) before the next. A waiting
// result does not block the next request as long as it is taken in the same cycle.
module line_rasterizer_step
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lrs_pkg::req_t req_data,
    output logic          res_valid,
    input  logic          res_ready,
    output lrs_pkg::res_t res_data
);
    import lrs_pkg::*;

    coord_t  cur_x_reg,    cur_x_next;
    coord_t  cur_y_reg,    cur_y_next;
    coord_t  target_x_reg, target_x_next;
    coord_t  target_y_reg, target_y_next;
    coord_t  mag_dx_reg,   mag_dx_next;
    coord_t  mag_dy_reg,   mag_dy_next;
    err_t    err_reg,      err_next;
    octant_t octant_reg,   octant_next;
    logic    finished_reg, finished_next;

    logic    res_valid_reg;
    res_t    res_data_reg, res_data_next;

    logic    accept;

    // Load path signals.
    logic signed [COORD_BITS:0] dx, dy;
    coord_t  ax, ay;
    octant_t load_oct;
    coord_t  load_maj, load_mnr;

    // Step path signals.
    logic    mx;
    coord_t  maj, mnr;
    logic    at_end;
    logic    err_pos;

    assign req_ready = !res_valid_reg || res_ready;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        dx = $signed({1'b0, req_data.end_x}) - $signed({1'b0, req_data.start_x});
        dy = $signed({1'b0, req_data.end_y}) - $signed({1'b0, req_data.start_y});
        ax = dx[COORD_BITS] ? coord_t'(-dx) : coord_t'(dx);
        ay = dy[COORD_BITS] ? coord_t'(-dy) : coord_t'(dy);

        // A zero-length line matches none of the sign tests and takes octant 0.
        if (!dx[COORD_BITS] && (dx != '0) && !dy[COORD_BITS])
        begin
            load_oct = (ax > ay) ? OCT_0 : OCT_1;
        end
        else if ((dx[COORD_BITS] || (dx == '0)) && !dy[COORD_BITS] && (dy != '0))
        begin
            load_oct = (ax < ay) ? OCT_2 : OCT_3;
        end
        else if (dx[COORD_BITS] && (dy[COORD_BITS] || (dy == '0)))
        begin
            load_oct = (ax >= ay) ? OCT_4 : OCT_5;
        end
        else if (!dx[COORD_BITS] && dy[COORD_BITS])
        begin
            load_oct = (ax < ay) ? OCT_6 : OCT_7;
        end
        else
        begin
            load_oct = OCT_0;
        end

        load_maj = major_is_x(load_oct) ? ax : ay;
        load_mnr = major_is_x(load_oct) ? ay : ax;
    end

    always_comb
    begin
        mx      = major_is_x(octant_reg);
        maj     = mx ? mag_dx_reg : mag_dy_reg;
        mnr     = mx ? mag_dy_reg : mag_dx_reg;
        at_end  = mx ? (cur_x_reg == target_x_reg) : (cur_y_reg == target_y_reg);
        err_pos = !err_reg[ERR_BITS-1] && (err_reg != '0);

        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        target_x_next = target_x_reg;
        target_y_next = target_y_reg;
        mag_dx_next   = mag_dx_reg;
        mag_dy_next   = mag_dy_reg;
        err_next      = err_reg;
        octant_next   = octant_reg;
        finished_next = finished_reg;

        case (req_data.action)
            ACT_LOAD:
            begin
                cur_x_next    = req_data.start_x;
                cur_y_next    = req_data.start_y;
                target_x_next = req_data.end_x;
                target_y_next = req_data.end_y;
                mag_dx_next   = ax;
                mag_dy_next   = ay;
                octant_next   = load_oct;
                err_next      = $signed({2'b00, load_mnr, 1'b0}) - $signed({3'b000, load_maj});
                finished_next = 1'b0;
            end
            ACT_STEP:
            begin
                if (!finished_reg)
                begin
                    if (at_end)
                    begin
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        // The minor axis moves when the decision term is positive.
                        err_next = err_reg + $signed({2'b00, mnr, 1'b0})
                                 - (err_pos ? $signed({2'b00, maj, 1'b0}) : err_t'(0));
                        if (mx)
                        begin
                            cur_x_next = move1(cur_x_reg, x_forward(octant_reg));
                            if (err_pos)
                            begin
                                cur_y_next = move1(cur_y_reg, y_forward(octant_reg));
                            end
                        end
                        else
                        begin
                            cur_y_next = move1(cur_y_reg, y_forward(octant_reg));
                            if (err_pos)
                            begin
                                cur_x_next = move1(cur_x_reg, x_forward(octant_reg));
                            end
                        end
                    end
                end
            end
            default:
            begin
                finished_next = finished_reg;
            end
        endcase

        res_data_next.point_x = cur_x_next;
        res_data_next.point_y = cur_y_next;
        res_data_next.on_line = !finished_next;
        res_data_next.octant  = octant_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            mag_dx_reg    <= '0;
            mag_dy_reg    <= '0;
            err_reg       <= '0;
            octant_reg    <= OCT_0;
            finished_reg  <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cur_x_reg    <= cur_x_next;
                cur_y_reg    <= cur_y_next;
                target_x_reg <= target_x_next;
                target_y_reg <= target_y_next;
                mag_dx_reg   <= mag_dx_next;
                mag_dy_reg   <= mag_dy_next;
                err_reg      <= err_next;
                octant_reg   <= octant_next;
                finished_reg <= finished_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // The decision term never leaves the band of plus or minus twice the major delta.
    assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg <= $signed({2'b00, maj, 1'b0})) && (err_reg >= -$signed({2'b00, maj, 1'b0})))
        else $error("decision term out of range");

    // A step on a finished line holds the position and reports off the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_data.action == ACT_STEP) && finished_reg) |=>
        (!res_data.on_line && (cur_x_reg == $past(cur_x_reg))
            && (cur_y_reg == $past(cur_y_reg))))
        else $error("finished line moved");

    // A load returns its start point on the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_data.action == ACT_LOAD)) |=>
        (res_valid && res_data.on_line && (res_data.point_x == $past(req_data.start_x))
            && (res_data.point_y == $past(req_data.start_y))))
        else $error("load result does not match start point");

endmodule
